// File: rtl/rpid_pkg.sv
// ----------------------------------------------------------------------------
// rpid_pkg
// Types, codes and constants shared by the run-length palette image decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rpid_pkg;

  // Largest width or height that a header may carry
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;
  localparam int WORD_W        = 16;

  // Palette: 256 RGB entries, loaded three bytes to an entry
  localparam int PAL_ENTRIES   = 256;
  localparam int PAL_AW        = 8;
  localparam int RGB_W         = 24;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_DIMS  = 2'd0;
  localparam logic [1:0] ERR_LINE  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_PAL  = 3'd2,
    PH_CLO  = 3'd3,
    PH_CHI  = 3'd4,
    PH_LIT  = 3'd5,
    PH_FILL = 3'd6
  } phase_t;

  // Result of one parser step, before the palette colour is attached
  typedef struct packed {
    logic [1:0]        kind;
    logic [DIM_W-1:0]  rep;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  img_h;
    logic [WORD_W-1:0] hot_x;
    logic [WORD_W-1:0] hot_y;
    logic [1:0]        err;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rpid_in_if.sv
// ----------------------------------------------------------------------------
// rpid_in_if
// Byte channel into the decoder: one file byte or marker per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;
  logic       end_of_data;

  modport source (output valid, output data_byte, output start_of_image,
                  output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input start_of_image,
                  input end_of_data, output ready);
endinterface

`default_nettype wire

// File: rtl/rpid_out_if.sv
// ----------------------------------------------------------------------------
// rpid_out_if
// Result channel of the decoder: pixel runs, header and error reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpid_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic [12:0]        repeat_count;
  logic [12:0]        image_width;
  logic [12:0]        image_height;
  logic signed [15:0] hot_x;
  logic signed [15:0] hot_y;
  logic [1:0]         error_code;
  logic               last;

  modport source (output valid, output kind, output red, output green,
                  output blue, output alpha, output repeat_count,
                  output image_width, output image_height, output hot_x,
                  output hot_y, output error_code, output last, input ready);
  modport sink   (input valid, input kind, input red, input green,
                  input blue, input alpha, input repeat_count,
                  input image_width, input image_height, input hot_x,
                  input hot_y, input error_code, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/rpid_ram.sv
// ----------------------------------------------------------------------------
// rpid_ram
// Generic single-write, single-read RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module rpid_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read while no new one is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/rpid_parser.sv
// ----------------------------------------------------------------------------
// rpid_parser
// Byte parser: header, palette load and run-length control words. Writes the
// palette RAM and produces one result descriptor per step that yields one.
// ----------------------------------------------------------------------------
`default_nettype none

module rpid_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [7:0]                 data_byte,
  input  wire logic                       start_of_image,
  input  wire logic                       end_of_data,
  output logic                            res_valid,
  output rpid_pkg::res_t                  res,
  output logic                            pal_we,
  output logic [rpid_pkg::PAL_AW-1:0]     pal_waddr,
  output logic [rpid_pkg::RGB_W-1:0]      pal_wdata
);

  localparam int DW = rpid_pkg::DIM_W;
  localparam int WW = rpid_pkg::WORD_W;

  rpid_pkg::phase_t phase_r, phase_nxt, ph_eff;

  logic [2:0]                  bc_r, bc_nxt, bc_eff;
  logic [rpid_pkg::PAL_AW-1:0] pal_idx_r, pal_idx_nxt;
  logic [1:0]                  pal_lane_r, pal_lane_nxt;
  logic [7:0]                  red_r, red_nxt, grn_r, grn_nxt;
  logic [WW-1:0]               hx_r, hx_nxt, hy_r, hy_nxt;
  logic [WW-1:0]               wd_r, wd_nxt, ht_r, ht_nxt;
  logic [DW-1:0]               row_r, row_nxt, col_r, col_nxt, run_r, run_nxt;
  logic [7:0]                  clo_r, clo_nxt;

  logic [WW-1:0] ht_new;
  logic          dims_bad;
  logic          pal_done;
  logic [WW-1:0] word;
  logic [WW-1:0] n_abs;
  logic [DW-1:0] room;
  logic          too_long;
  logic [DW-1:0] n_px;
  logic [DW-1:0] col_sum;
  logic [DW-1:0] row_inc;
  logic          line_end;
  logic          img_done;

  assign ph_eff = start_of_image ? rpid_pkg::PH_HEAD : phase_r;
  assign bc_eff = start_of_image ? 3'd0 : bc_r;

  // Height completes with the last header byte
  assign ht_new   = {data_byte, ht_r[7:0]};
  assign dims_bad = (wd_r == '0) || (ht_new == '0) || wd_r[WW-1] || ht_new[WW-1] ||
                    (wd_r > WW'(rpid_pkg::MAX_DIMENSION)) ||
                    (ht_new > WW'(rpid_pkg::MAX_DIMENSION));

  assign pal_done = (pal_lane_r == 2'd2) &&
                    (pal_idx_r == rpid_pkg::PAL_AW'(rpid_pkg::PAL_ENTRIES - 1));

  assign word     = {data_byte, clo_r};
  assign n_abs    = word[WW-1] ? (WW'(0) - word) : word;
  assign room     = wd_r[DW-1:0] - col_r;
  assign too_long = n_abs > {{(WW-DW){1'b0}}, room};

  // Position update for an emitted run
  assign n_px     = (ph_eff == rpid_pkg::PH_LIT) ? DW'(1) : run_r;
  assign col_sum  = col_r + n_px;
  assign row_inc  = row_r + DW'(1);
  assign line_end = {{(WW-DW){1'b0}}, col_sum} >= wd_r;
  assign img_done = line_end && ({{(WW-DW){1'b0}}, row_inc} >= ht_r);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (end_of_data) begin
        phase_nxt = rpid_pkg::PH_IDLE;
      end else begin
        unique case (ph_eff)
          rpid_pkg::PH_IDLE: phase_nxt = rpid_pkg::PH_IDLE;
          rpid_pkg::PH_HEAD: begin
            if (bc_eff == 3'd7) begin
              phase_nxt = dims_bad ? rpid_pkg::PH_IDLE : rpid_pkg::PH_PAL;
            end else begin
              phase_nxt = rpid_pkg::PH_HEAD;
            end
          end
          rpid_pkg::PH_PAL: phase_nxt = pal_done ? rpid_pkg::PH_CLO : rpid_pkg::PH_PAL;
          rpid_pkg::PH_CLO: phase_nxt = rpid_pkg::PH_CHI;
          rpid_pkg::PH_CHI: begin
            if (word == '0) begin
              phase_nxt = rpid_pkg::PH_FILL;
            end else if (too_long) begin
              phase_nxt = rpid_pkg::PH_IDLE;
            end else begin
              phase_nxt = word[WW-1] ? rpid_pkg::PH_FILL : rpid_pkg::PH_LIT;
            end
          end
          rpid_pkg::PH_LIT: begin
            if (img_done) begin
              phase_nxt = rpid_pkg::PH_IDLE;
            end else if (run_r == DW'(1)) begin
              phase_nxt = rpid_pkg::PH_CLO;
            end else begin
              phase_nxt = rpid_pkg::PH_LIT;
            end
          end
          rpid_pkg::PH_FILL: begin
            if ((run_r != '0) && img_done) begin
              phase_nxt = rpid_pkg::PH_IDLE;
            end else begin
              phase_nxt = rpid_pkg::PH_CLO;
            end
          end
          default: phase_nxt = rpid_pkg::PH_IDLE;
        endcase
      end
    end
  end

  // Datapath and results
  always_comb begin
    bc_nxt       = bc_r;
    pal_idx_nxt  = pal_idx_r;
    pal_lane_nxt = pal_lane_r;
    red_nxt      = red_r;
    grn_nxt      = grn_r;
    hx_nxt       = hx_r;
    hy_nxt       = hy_r;
    wd_nxt       = wd_r;
    ht_nxt       = ht_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    run_nxt      = run_r;
    clo_nxt      = clo_r;
    res_valid    = 1'b0;
    res          = '0;
    pal_we       = 1'b0;
    pal_waddr    = pal_idx_r;
    pal_wdata    = {red_r, grn_r, data_byte};

    if (take) begin
      if (end_of_data) begin
        if (phase_r != rpid_pkg::PH_IDLE) begin
          res_valid = 1'b1;
          res.kind  = rpid_pkg::KIND_ERROR;
          res.err   = rpid_pkg::ERR_TRUNC;
          res.last  = 1'b1;
        end
      end else begin
        if (start_of_image) begin
          row_nxt = '0;
          col_nxt = '0;
          run_nxt = '0;
        end
        case (ph_eff)
          rpid_pkg::PH_HEAD: begin
            bc_nxt = bc_eff + 3'd1;
            case (bc_eff)
              3'd0: hx_nxt[7:0]  = data_byte;
              3'd1: hx_nxt[15:8] = data_byte;
              3'd2: hy_nxt[7:0]  = data_byte;
              3'd3: hy_nxt[15:8] = data_byte;
              3'd4: wd_nxt[7:0]  = data_byte;
              3'd5: wd_nxt[15:8] = data_byte;
              3'd6: ht_nxt[7:0]  = data_byte;
              default: ht_nxt[15:8] = data_byte;
            endcase
            if (bc_eff == 3'd7) begin
              pal_idx_nxt  = '0;
              pal_lane_nxt = '0;
              res_valid    = 1'b1;
              if (dims_bad) begin
                res.kind = rpid_pkg::KIND_ERROR;
                res.err  = rpid_pkg::ERR_DIMS;
                res.last = 1'b1;
              end else begin
                res.kind  = rpid_pkg::KIND_HEADER;
                res.img_w = wd_r[DW-1:0];
                res.img_h = ht_new[DW-1:0];
                res.hot_x = hx_r;
                res.hot_y = hy_r;
              end
            end
          end
          rpid_pkg::PH_PAL: begin
            case (pal_lane_r)
              2'd0:    red_nxt = data_byte;
              2'd1:    grn_nxt = data_byte;
              default: begin
                pal_we      = 1'b1;
                pal_idx_nxt = pal_idx_r + rpid_pkg::PAL_AW'(1);
              end
            endcase
            pal_lane_nxt = (pal_lane_r == 2'd2) ? 2'd0 : pal_lane_r + 2'd1;
          end
          rpid_pkg::PH_CLO: clo_nxt = data_byte;
          rpid_pkg::PH_CHI: begin
            if (word == '0) begin
              run_nxt = '0;
            end else if (too_long) begin
              res_valid = 1'b1;
              res.kind  = rpid_pkg::KIND_ERROR;
              res.err   = rpid_pkg::ERR_LINE;
              res.last  = 1'b1;
            end else begin
              run_nxt = n_abs[DW-1:0];
            end
          end
          rpid_pkg::PH_LIT, rpid_pkg::PH_FILL: begin
            if (ph_eff == rpid_pkg::PH_LIT) begin
              run_nxt = run_r - DW'(1);
            end
            if ((ph_eff == rpid_pkg::PH_LIT) || (run_r != '0)) begin
              res_valid = 1'b1;
              res.kind  = rpid_pkg::KIND_PIXEL;
              res.rep   = n_px;
              res.last  = img_done;
              col_nxt   = line_end ? '0 : col_sum;
              row_nxt   = line_end ? row_inc : row_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rpid_pkg::PH_IDLE;
      bc_r       <= '0;
      pal_idx_r  <= '0;
      pal_lane_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
      run_r      <= '0;
      clo_r      <= '0;
      hx_r       <= '0;
      hy_r       <= '0;
      wd_r       <= '0;
      ht_r       <= '0;
    end else begin
      phase_r    <= phase_nxt;
      bc_r       <= bc_nxt;
      pal_idx_r  <= pal_idx_nxt;
      pal_lane_r <= pal_lane_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      run_r      <= run_nxt;
      clo_r      <= clo_nxt;
      hx_r       <= hx_nxt;
      hy_r       <= hy_nxt;
      wd_r       <= wd_nxt;
      ht_r       <= ht_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r <= red_nxt;
    grn_r <= grn_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/rpid_out_stage.sv
// ----------------------------------------------------------------------------
// rpid_out_stage
// Two-entry result path: a pending slot that waits for the palette read and
// the output register that drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rpid_out_stage (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      take,
  input  wire logic                      res_valid,
  input  wire rpid_pkg::res_t            res,
  input  wire logic [rpid_pkg::RGB_W-1:0] pal_rdata,
  output logic                           can_take,
  rpid_out_if.source                     out_ch
);

  logic           pend_v_r, pend_v_nxt;
  rpid_pkg::res_t pend_r;
  logic           out_v_r, out_v_nxt;
  rpid_pkg::res_t out_r;
  logic [rpid_pkg::RGB_W-1:0] rgb_r;
  logic           adv;

  // Palette data belongs to the pending transaction until the next read
  assign adv      = pend_v_r && (!out_v_r || out_ch.ready);
  assign can_take = !pend_v_r || !out_v_r || out_ch.ready;

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (take) begin
      pend_v_nxt = res_valid;
    end else if (adv) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= res;
    end
    if (adv) begin
      out_r <= pend_r;
      rgb_r <= (pend_r.kind == rpid_pkg::KIND_PIXEL) ? pal_rdata : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.red          = rgb_r[23:16];
  assign out_ch.green        = rgb_r[15:8];
  assign out_ch.blue         = rgb_r[7:0];
  assign out_ch.alpha        = rpid_pkg::ALPHA_OPAQUE;
  assign out_ch.repeat_count = out_r.rep;
  assign out_ch.image_width  = out_r.img_w;
  assign out_ch.image_height = out_r.img_h;
  assign out_ch.hot_x        = $signed(out_r.hot_x);
  assign out_ch.hot_y        = $signed(out_r.hot_y);
  assign out_ch.error_code   = out_r.err;
  assign out_ch.last         = out_r.last;

endmodule

`default_nettype wire

// File: rtl/rle_palette_image_decoder_unit.sv
// ----------------------------------------------------------------------------
// rle_palette_image_decoder_unit
// Run-length image decoder with a 256-entry RGB palette.
//
// in_ch carries one file byte per transaction, with start_of_image on the
// first header byte and end_of_data as a byte-less marker at stream end.
// out_ch carries header, pixel-run and error results, at most one per byte.
// One byte is taken every cycle while results flow; a result passes through
// the pending slot, where the palette RAM read of the index byte completes,
// and then the output register before it appears on out_ch.
// The palette lives in a synchronous RAM written once per three palette
// bytes and read once per accepted byte.
// When out_ch stalls, one further result is parked in the pending slot;
// in_ch.ready then drops until the output register frees up.
// Reset returns the parser to idle and empties both result slots; the
// palette RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_palette_image_decoder_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rpid_in_if.sink    in_ch,
  rpid_out_if.source out_ch
);

  logic                            take;
  logic                            can_take;
  logic                            res_valid;
  rpid_pkg::res_t                  res;
  logic                            pal_we;
  logic [rpid_pkg::PAL_AW-1:0]     pal_waddr;
  logic [rpid_pkg::RGB_W-1:0]      pal_wdata;
  logic [rpid_pkg::RGB_W-1:0]      pal_rdata;

  assign in_ch.ready = can_take;
  assign take        = in_ch.valid && can_take;

  rpid_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_ch.data_byte),
    .start_of_image (in_ch.start_of_image),
    .end_of_data    (in_ch.end_of_data),
    .res_valid      (res_valid),
    .res            (res),
    .pal_we         (pal_we),
    .pal_waddr      (pal_waddr),
    .pal_wdata      (pal_wdata)
  );

  // Read the index byte on every transaction; only pixel results use it
  rpid_ram #(
    .WIDTH (rpid_pkg::RGB_W),
    .DEPTH (rpid_pkg::PAL_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (take),
    .raddr (in_ch.data_byte),
    .rdata (pal_rdata)
  );

  rpid_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .pal_rdata (pal_rdata),
    .can_take  (can_take),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: bench/rpid_decode_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpid_decode_check
// Watches both channels of the decoder, predicts every result from the
// accepted bytes and compares each result transaction field by field.
// ----------------------------------------------------------------------------

module rpid_decode_check
  import rpid_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rpid_in_if   in_ch,
  rpid_out_if  out_ch,
  output int   mismatches,
  output int   runs_owed
);

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [DIM_W-1:0]  rep;
    logic [DIM_W-1:0]  img_w;
    logic [DIM_W-1:0]  img_h;
    logic [WORD_W-1:0] hot_x;
    logic [WORD_W-1:0] hot_y;
    logic [1:0]        err;
    logic              last;
  } decoded_run_t;

  decoded_run_t pending_runs[$];

  // Shadow copy of the parser
  phase_t            parse_phase;
  int unsigned       byte_cnt;
  logic [WORD_W-1:0] hdr [4];
  logic [RGB_W-1:0]  palette [PAL_ENTRIES];
  int unsigned       row;
  int unsigned       col;
  int unsigned       run_left;
  logic [7:0]        ctl_lo;

  initial begin
    mismatches  = 0;
    runs_owed   = 0;
    parse_phase = PH_IDLE;
    byte_cnt    = 0;
    row         = 0;
    col         = 0;
    run_left    = 0;
    ctl_lo      = 8'h00;
    for (int i = 0; i < 4; i++) hdr[i] = '0;
    for (int i = 0; i < PAL_ENTRIES; i++) palette[i] = '0;
  end

  function automatic void post(logic [1:0] kind, logic [RGB_W-1:0] rgb, logic [DIM_W-1:0] rep,
                               logic [WORD_W-1:0] w, logic [WORD_W-1:0] h,
                               logic [WORD_W-1:0] hx, logic [WORD_W-1:0] hy,
                               logic [1:0] err, logic last);
    decoded_run_t r;
    r.kind  = kind;
    r.red   = rgb[23:16];
    r.green = rgb[15:8];
    r.blue  = rgb[7:0];
    r.alpha = ALPHA_OPAQUE;
    r.rep   = rep;
    r.img_w = w[DIM_W-1:0];
    r.img_h = h[DIM_W-1:0];
    r.hot_x = hx;
    r.hot_y = hy;
    r.err   = err;
    r.last  = last;
    pending_runs.push_back(r);
  endfunction

  function automatic void flag_error(logic [1:0] code);
    parse_phase = PH_IDLE;
    post(KIND_ERROR, '0, '0, '0, '0, '0, '0, code, 1'b1);
  endfunction

  function automatic void post_pixels(logic [7:0] idx, int unsigned n);
    logic done;
    done = 1'b0;
    col  = (col + n) & 32'h1FFF;
    if (col >= hdr[2]) begin
      col = 0;
      row = (row + 1) & 32'h1FFF;
      if (row >= hdr[3]) done = 1'b1;
    end
    post(KIND_PIXEL, palette[idx], DIM_W'(n), '0, '0, '0, '0, '0, done);
    if (done) parse_phase = PH_IDLE;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic sos, logic eod);
    int unsigned k;
    int unsigned word;
    int unsigned room;
    int unsigned n;
    int unsigned ent;
    if (eod) begin
      if (parse_phase != PH_IDLE) flag_error(ERR_TRUNC);
      return;
    end
    if (sos) begin
      parse_phase = PH_HEAD;
      byte_cnt    = 0;
      row         = 0;
      col         = 0;
      run_left    = 0;
    end
    case (parse_phase)
      PH_HEAD: begin
        k = (byte_cnt >> 1) & 3;
        if (byte_cnt[0]) hdr[k][15:8] = b;
        else hdr[k] = {8'h00, b};
        byte_cnt++;
        if (byte_cnt >= 8) begin
          byte_cnt = 0;
          if (hdr[2] == 0 || hdr[3] == 0 || hdr[2][15] || hdr[3][15] ||
              hdr[2] > MAX_DIMENSION || hdr[3] > MAX_DIMENSION) begin
            flag_error(ERR_DIMS);
          end else begin
            parse_phase = PH_PAL;
            post(KIND_HEADER, '0, '0, hdr[2], hdr[3], hdr[0], hdr[1], '0, 1'b0);
          end
        end
      end
      PH_PAL: begin
        ent = (byte_cnt / 3) & 8'hFF;
        case (byte_cnt % 3)
          0:       palette[ent][23:16] = b;
          1:       palette[ent][15:8]  = b;
          default: palette[ent][7:0]   = b;
        endcase
        byte_cnt++;
        if (byte_cnt >= PAL_ENTRIES * 3) begin
          byte_cnt    = 0;
          parse_phase = PH_CLO;
        end
      end
      PH_CLO: begin
        ctl_lo      = b;
        parse_phase = PH_CHI;
      end
      PH_CHI: begin
        word = {b, ctl_lo};
        room = hdr[2] - col;
        if (word == 0) begin
          // zero word: swallow the next byte without a run
          run_left    = 0;
          parse_phase = PH_FILL;
        end else begin
          n = word[15] ? 32'h10000 - word : word;
          if (n > room) begin
            flag_error(ERR_LINE);
          end else begin
            run_left    = n;
            parse_phase = word[15] ? PH_FILL : PH_LIT;
          end
        end
      end
      PH_LIT: begin
        run_left = (run_left - 1) & 32'h1FFF;
        if (run_left == 0) parse_phase = PH_CLO;
        post_pixels(b, 1);
      end
      PH_FILL: begin
        parse_phase = PH_CLO;
        if (run_left != 0) post_pixels(b, run_left);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    decoded_run_t seen;
    decoded_run_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        decode_byte(in_ch.data_byte, in_ch.start_of_image, in_ch.end_of_data);
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.kind, out_ch.red, out_ch.green, out_ch.blue, out_ch.alpha,
                 out_ch.repeat_count, out_ch.image_width, out_ch.image_height,
                 out_ch.hot_x, out_ch.hot_y, out_ch.error_code, out_ch.last};
        if (pending_runs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, seen);
        end else begin
          want = pending_runs.pop_front();
          check_field("kind", want.kind, seen.kind);
          check_field("red", want.red, seen.red);
          check_field("green", want.green, seen.green);
          check_field("blue", want.blue, seen.blue);
          check_field("alpha", want.alpha, seen.alpha);
          check_field("repeat_count", want.rep, seen.rep);
          check_field("image_width", want.img_w, seen.img_w);
          check_field("image_height", want.img_h, seen.img_h);
          check_field("hot_x", want.hot_x, seen.hot_x);
          check_field("hot_y", want.hot_y, seen.hot_y);
          check_field("error_code", want.err, seen.err);
          check_field("last", want.last, seen.last);
        end
      end
      runs_owed = pending_runs.size();
    end
  end

endmodule

// File: bench/rle_palette_image_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rle_palette_image_decoder_unit_tb
// Feeds the decoder headers, palettes and run-length lines, both well formed
// and broken, with random sender gaps and receiver stalls; rpid_decode_check
// predicts and compares every result.
// ----------------------------------------------------------------------------

module rle_palette_image_decoder_unit_tb;
  import rpid_pkg::*;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKED,
    RX_PERIODIC
  } rx_mode_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   runs_owed;
  int   items_sent;
  int   burst_left;

  rx_mode_t    rx_mode  = RX_OPEN;
  int unsigned rx_left  = 0;
  int unsigned rx_tick  = 0;

  rpid_in_if  in_ch ();
  rpid_out_if out_ch ();

  rle_palette_image_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpid_decode_check decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .runs_owed  (runs_owed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial out_ch.ready = 1'b0;

  // Receiver: switch stall mode after a random stretch in each mode
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
      RX_CHOKED: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   out_ch.ready <= (rx_tick % 7) > 2;
    endcase
  end

  task automatic push_byte(input logic [7:0] b, input logic sos, input logic eod,
                           input bit counted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.start_of_image <= sos;
    in_ch.end_of_data    <= eod;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (counted) items_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    push_byte(w[7:0], 1'b0, 1'b0, 1'b1);
    push_byte(w[15:8], 1'b0, 1'b0, 1'b1);
  endtask

  task automatic send_header(input logic [15:0] hx, input logic [15:0] hy,
                             input logic [15:0] w, input logic [15:0] h);
    push_byte(hx[7:0], 1'b1, 1'b0, 1'b1);
    push_byte(hx[15:8], 1'b0, 1'b0, 1'b1);
    send_word(hy);
    send_word(w);
    send_word(h);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (runs_owed != 0);
  endtask

  function automatic logic [15:0] good_dim();
    case ($urandom_range(0, 9))
      0:       return 16'd1;
      1:       return 16'(MAX_DIMENSION);
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [15:0] bad_dim();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'h8000 | 16'($urandom);
      2:       return 16'($urandom_range(MAX_DIMENSION + 1, 32767));
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic send_image(input bit big, input bit faults);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned col;
    int unsigned room;
    int unsigned n;
    int unsigned pick;
    logic [15:0] word;
    bit          stop;
    w = big ? MAX_DIMENSION : $urandom_range(1, 12);
    h = big ? 2 : $urandom_range(1, 4);
    send_header(16'($urandom), 16'($urandom), 16'(w), 16'(h));
    repeat (PAL_ENTRIES * 3) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
    stop = 1'b0;
    r    = 0;
    while (r < h && !stop) begin
      col = 0;
      while (col < w && !stop) begin
        room = w - col;
        pick = faults ? $urandom_range(0, 99) : $urandom_range(0, 87);
        if (pick < 40) begin
          n = $urandom_range(1, room < 6 ? room : 6);
          send_word(16'(n));
          repeat (n) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
          col += n;
        end else if (pick < 80) begin
          n = ($urandom_range(0, 3) == 0) ? room : $urandom_range(1, room);
          send_word(16'(32'h10000 - n));
          push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
          col += n;
        end else if (pick < 88) begin
          send_word(16'h0000);
          push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
        end else if (pick < 93) begin
          // run longer than what is left of the line
          case ($urandom_range(0, 3))
            0:       word = 16'h8000;
            1:       word = 16'h7FFF;
            2:       word = 16'(room + $urandom_range(1, 8));
            default: word = 16'(32'h10000 - room - $urandom_range(1, 8));
          endcase
          send_word(word);
          stop = 1'b1;
        end else if (pick < 97) begin
          if ($urandom_range(0, 1)) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
          stop = 1'b1;
        end else begin
          // abandon; a later start of image restarts the parser
          if ($urandom_range(0, 1)) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
          stop = 1'b1;
        end
      end
      r++;
    end
  endtask

  initial begin
    int          full_images;
    int unsigned pick;
    int unsigned k;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = 8'h00;
    in_ch.start_of_image = 1'b0;
    in_ch.end_of_data    = 1'b0;
    rst_n                = 1'b0;
    items_sent           = 0;
    burst_left           = 0;
    full_images          = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An idle marker and a stray byte, rejected headers, largest header then a truncation
    push_byte(8'hA5, 1'b0, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0, 1'b0);
    send_header(16'h8000, 16'h7FFF, 16'h0000, 16'h0001);
    send_header(16'hFFFF, 16'h0000, 16'(MAX_DIMENSION), 16'(MAX_DIMENSION + 1));
    send_header(16'h7FFF, 16'h8000, 16'(MAX_DIMENSION), 16'(MAX_DIMENSION));
    push_byte(8'hFF, 1'b1, 1'b1, 1'b1);
    hold_until_drained();

    while (items_sent < 1000 || full_images < 1) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // first image is the widest and runs clean to the end; later ones may break
        send_image(full_images == 0, full_images != 0);
        full_images++;
      end else if (pick < 62) begin
        case ($urandom_range(0, 2))
          0:       send_header(16'($urandom), 16'($urandom), bad_dim(), good_dim());
          1:       send_header(16'($urandom), 16'($urandom), good_dim(), bad_dim());
          default: send_header(16'($urandom), 16'($urandom), bad_dim(), bad_dim());
        endcase
      end else if (pick < 74) begin
        // palette cut short by end of data or by a restart
        send_header(16'($urandom), 16'($urandom), good_dim(), good_dim());
        k = $urandom_range(0, PAL_ENTRIES * 3 - 1);
        repeat (k) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
        if ($urandom_range(0, 1))
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      end else if (pick < 86) begin
        k = $urandom_range(1, 7);
        push_byte(8'($urandom), 1'b1, 1'b0, 1'b1);
        repeat (k - 1) push_byte(8'($urandom), 1'b0, 1'b0, 1'b1);
        if ($urandom_range(0, 1))
          push_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 1'b0);
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end

    in_ch.valid <= 1'b0;
    wait (runs_owed == 0);
    repeat (16) @(negedge clk);
    if (mismatches == 0 && runs_owed == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
rtl/rpid_pkg.sv
rtl/rpid_in_if.sv
rtl/rpid_out_if.sv
rtl/rpid_ram.sv
rtl/rpid_parser.sv
rtl/rpid_out_stage.sv
rtl/rle_palette_image_decoder_unit.sv
bench/rpid_decode_check.sv
bench/rle_palette_image_decoder_unit_tb.sv
